// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/adcsp_pkg.sv =====
package adcsp_pkg;

    localparam int WAYS   = 8;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FLOWS  = 256;
    localparam int FLOW_W = $clog2(FLOWS);

    localparam int LAT_W  = 16;
    localparam int TIME_W = 32;
    localparam int SUM_W  = 48;
    localparam int DIV_W  = TIME_W + 1;
    localparam int PA_W   = SUM_W + TIME_W;
    localparam int PROD_W = PA_W + DIV_W;
    localparam int DIGIT_W = 16;
    localparam int DIGITS  = PA_W / DIGIT_W;

    localparam logic [LAT_W-1:0] LAT_RESET = LAT_W'(100);

    localparam logic [1:0] MSEL_CS_BW = 2'd0;
    localparam logic [1:0] MSEL_X_BD  = 2'd1;
    localparam logic [1:0] MSEL_BS_CW = 2'd2;
    localparam logic [1:0] MSEL_X_CD  = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [7:0]        flow_id;
        logic [TIME_W-1:0] clock_tick;
    } in_t;

    typedef struct packed {
        logic       hit;
        logic       evicted;
        logic [7:0] evicted_flow;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0] window_count;
        logic [TIME_W-1:0] last_arrival;
        logic [TIME_W-1:0] queue_start;
        logic [SUM_W-1:0]  delay_sum;
    } rec_t;

    typedef struct packed {
        logic             load;
        logic             rd_arr;
        logic             wr_arr;
        logic             rd_way;
        logic             term;
        logic             take;
        logic             mul_go;
        logic [1:0]       mul_sel;
        logic             save_t1;
        logic             do_hit;
        logic             do_fill;
        logic             do_evict;
        logic [WAY_W-1:0] way_idx;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic hit;
        logic free;
        logic mul_done;
        logic less;
    } stat_t;

endpackage

// ===== rtl/core/adcsp_mul.sv =====
module adcsp_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [adcsp_pkg::PA_W-1:0]   a,
    input  logic [adcsp_pkg::DIV_W-1:0]  b,
    output logic                         done,
    output logic [adcsp_pkg::PROD_W-1:0] p
);
    import adcsp_pkg::*;

    localparam int CNT_W = $clog2(DIGITS + 1);

    logic [PA_W-1:0]   a_reg, a_next;
    logic [DIV_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIGIT_W+DIV_W-1:0] part;

    assign part = a_reg[PA_W-1 -: DIGIT_W] * b_reg;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = (acc_reg << DIGIT_W) + PROD_W'(part);
            a_next   = a_reg << DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== rtl/core/adcsp_dp.sv =====
module adcsp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  adcsp_pkg::in_t              item,
    input  logic                        cfg_valid,
    input  logic [adcsp_pkg::LAT_W-1:0] cfg_data,
    input  adcsp_pkg::cmd_t             cmd,
    output adcsp_pkg::stat_t            stat,
    output adcsp_pkg::out_t             result,
    output logic                        done
);
    import adcsp_pkg::*;

    logic [LAT_W-1:0]  lat_reg;
    in_t               in_reg;
    rec_t              mem [FLOWS];
    rec_t              mem_q;
    logic [FLOWS-1:0]  seen_reg;
    logic              seen_q;
    logic [FLOW_W-1:0] rd_addr;
    logic              rd_en;
    rec_t              rec;
    rec_t              wr_rec;
    logic [FLOW_W-1:0] fidx;

    logic [WAYS-1:0]   way_valid_reg;
    logic [7:0]        way_flow_reg [WAYS];
    logic [WAYS-1:0]   match;
    logic [WAY_W-1:0]  free_idx;

    logic [SUM_W-1:0]  cs_reg, bs_reg;
    logic [TIME_W-1:0] cw_reg, bw_reg;
    logic [DIV_W-1:0]  cd_reg, bd_reg;
    logic [WAY_W-1:0]  best_reg;
    logic [PROD_W-1:0] t1_reg;

    logic [PA_W-1:0]   mul_a;
    logic [DIV_W-1:0]  mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_p;

    out_t              res_reg, res_next;
    logic              done_reg, done_next;

    logic [TIME_W-1:0] tssq;
    logic              new_win;
    logic [SUM_W:0]    sum_ext;
    logic [LAT_W-1:0]  add;

    assign fidx = in_reg.flow_id[FLOW_W-1:0];
    assign rec  = seen_q ? mem_q : '0;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lat_reg <= LAT_RESET;
        else if (cfg_valid)
            lat_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= item;
    end

    // Flow table
    always_comb
    begin
        rd_en   = cmd.rd_arr | cmd.rd_way;
        rd_addr = cmd.rd_way ? way_flow_reg[cmd.way_idx][FLOW_W-1:0] : fidx;
    end

    always_comb
    begin
        tssq    = in_reg.clock_tick - rec.queue_start;
        new_win = !seen_q || (tssq >= TIME_W'(lat_reg));
        add     = new_win ? lat_reg : LAT_W'(TIME_W'(lat_reg) - tssq);
        wr_rec  = rec;
        if (new_win)
        begin
            if (rec.window_count != '1)
                wr_rec.window_count = rec.window_count + 1'b1;
            wr_rec.queue_start = in_reg.clock_tick;
        end
        sum_ext = {1'b0, rec.delay_sum} + (SUM_W + 1)'(add);
        wr_rec.delay_sum    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        wr_rec.last_arrival = in_reg.clock_tick;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q <= mem[rd_addr];
        if (cmd.wr_arr)
            mem[fidx] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            seen_q   <= 1'b0;
        end
        else
        begin
            if (rd_en)
                seen_q <= seen_reg[rd_addr];
            if (cmd.wr_arr)
                seen_reg[fidx] <= 1'b1;
        end
    end

    // Ways
    always_comb
    begin
        free_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            match[i] = way_valid_reg[i] && (way_flow_reg[i] == in_reg.flow_id);
            if (!way_valid_reg[i])
                free_idx = WAY_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            way_valid_reg <= '0;
        else if (cmd.do_fill)
            way_valid_reg[free_idx] <= 1'b1;
        else if (cmd.do_evict)
            way_valid_reg[best_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_fill)
            way_flow_reg[free_idx] <= in_reg.flow_id;
        else if (cmd.do_evict)
            way_flow_reg[best_reg] <= in_reg.flow_id;
    end

    // Cost terms
    always_ff @(posedge clk)
    begin
        if (cmd.term)
        begin
            cs_reg <= rec.delay_sum;
            cw_reg <= (rec.window_count == '0) ? TIME_W'(1) : rec.window_count;
            cd_reg <= {1'b0, in_reg.clock_tick - rec.last_arrival} + DIV_W'(1);
        end
        if (cmd.take)
        begin
            bs_reg   <= cs_reg;
            bw_reg   <= cw_reg;
            bd_reg   <= cd_reg;
            best_reg <= cmd.way_idx;
        end
        if (cmd.save_t1)
            t1_reg <= mul_p;
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_CS_BW:
            begin
                mul_a = PA_W'(cs_reg);
                mul_b = DIV_W'(bw_reg);
            end
            MSEL_X_BD:
            begin
                mul_a = mul_p[PA_W-1:0];
                mul_b = bd_reg;
            end
            MSEL_BS_CW:
            begin
                mul_a = PA_W'(bs_reg);
                mul_b = DIV_W'(cw_reg);
            end
            MSEL_X_CD:
            begin
                mul_a = mul_p[PA_W-1:0];
                mul_b = cd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    adcsp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Result
    always_comb
    begin
        res_next  = res_reg;
        done_next = 1'b0;
        if (cmd.wr_arr || cmd.do_fill)
        begin
            res_next  = '0;
            done_next = 1'b1;
        end
        else if (cmd.do_hit)
        begin
            res_next     = '0;
            res_next.hit = 1'b1;
            done_next    = 1'b1;
        end
        else if (cmd.do_evict)
        begin
            res_next.hit          = 1'b0;
            res_next.evicted      = 1'b1;
            res_next.evicted_flow = way_flow_reg[best_reg];
            done_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign stat.mode     = in_reg.mode;
    assign stat.hit      = |match;
    assign stat.free     = ~&way_valid_reg;
    assign stat.mul_done = mul_done;
    assign stat.less     = t1_reg < mul_p;
    assign result        = res_reg;
    assign done          = done_reg;

endmodule

// ===== rtl/core/adcsp_ctrl.sv =====
module adcsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  adcsp_pkg::stat_t stat,
    output adcsp_pkg::cmd_t  cmd,
    output logic             busy
);
    import adcsp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ARD   = 4'd1;
    localparam logic [3:0] S_AWR   = 4'd2;
    localparam logic [3:0] S_WCHK  = 4'd3;
    localparam logic [3:0] S_ERD   = 4'd4;
    localparam logic [3:0] S_ETRM  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_ECMP  = 4'd8;
    localparam logic [3:0] S_EFIN  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [WAY_W-1:0] way_reg, way_next;
    logic [1:0]       step_reg, step_next;

    always_comb
    begin
        state_next  = state_reg;
        way_next    = way_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.way_idx = way_reg;
        cmd.mul_sel = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                if (stat.mode)
                    state_next = S_WCHK;
                else
                begin
                    cmd.rd_arr = 1'b1;
                    state_next = S_AWR;
                end
            end
            S_AWR:
            begin
                cmd.wr_arr = 1'b1;
                state_next = S_IDLE;
            end
            S_WCHK:
            begin
                way_next = '0;
                if (stat.hit)
                begin
                    cmd.do_hit = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.free)
                begin
                    cmd.do_fill = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_ERD;
            end
            S_ERD:
            begin
                cmd.rd_way = 1'b1;
                state_next = S_ETRM;
            end
            S_ETRM:
            begin
                cmd.term   = 1'b1;
                step_next  = MSEL_CS_BW;
                state_next = (way_reg == '0) ? S_ECMP : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.save_t1 = (step_reg == MSEL_X_BD);
                    step_next   = step_reg + 1'b1;
                    state_next  = (step_reg == MSEL_X_CD) ? S_ECMP : S_MUL;
                end
            end
            S_ECMP:
            begin
                cmd.take = (way_reg == '0) || stat.less;
                if (way_reg == WAY_W'(WAYS - 1))
                    state_next = S_EFIN;
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_EFIN:
            begin
                cmd.do_evict = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            way_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            way_reg   <= way_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/aggregate_delay_cache_set_policy.sv =====
// One cache set with delay-aware replacement. Mode 0 records an arrival in a
// 256-entry flow table. Mode 1 writes a key: a hit or a free way is settled
// in the way check; an eviction into a full set costs each way but way 0
// two triple products on a shared 16-bit-digit multiplier. busy drops in
// the cycle the result strobe is high; done marks the one cycle result is
// valid and cannot be stalled by the receiver.
module aggregate_delay_cache_set_policy (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  adcsp_pkg::in_t              item,
    output adcsp_pkg::out_t             result,
    output logic                        done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [adcsp_pkg::LAT_W-1:0] cfg_data
);
    import adcsp_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  busy_int;

    adcsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy_int)
    );

    adcsp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result),
        .done      (done)
    );

    assign busy      = busy_int;
    assign cfg_ready = ~busy_int;

endmodule

// ===== rtl/core/adcsp_checker.sv =====
`include "assert_macros.svh"

module adcsp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input adcsp_pkg::out_t result
);
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_done_after_busy, clk, rst_n, done, $past(busy))
    `ASSERT_IMPLY(a_hit_no_evict, clk, rst_n, done && result.hit, !result.evicted)
    `ASSERT_IMPLY(a_flow_zero, clk, rst_n, done && !result.evicted, result.evicted_flow == 8'd0)
endmodule

bind aggregate_delay_cache_set_policy adcsp_checker u_adcsp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
